// ----- design/clas_pkg.sv -----
// Shared types, constants and helper functions for the crop luma statistics block.
`timescale 1ns / 1ps
package clas_pkg;

  // Field widths
  localparam int LUMA_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DIM_CFG_W  = 8;
  localparam int THR_W      = 17;
  localparam int OUT_CNT_W  = 14;
  localparam int FRAC_SHIFT = 16;

  // Default geometry limits
  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  // Register reset values
  localparam logic [DIM_CFG_W-1:0] CROP_WIDTH_RST  = 8'd79;
  localparam logic [DIM_CFG_W-1:0] CROP_HEIGHT_RST = 8'd79;
  localparam logic [LUMA_W-1:0]    LUMA_RANGE_RST  = 8'd16;
  localparam logic [THR_W-1:0]     EDGE_FRAC_RST   = 17'd3277;

  // Luma weights and edge threshold
  localparam logic [15:0] COEF_BLUE  = 16'd29;
  localparam logic [15:0] COEF_GREEN = 16'd150;
  localparam logic [15:0] COEF_RED   = 16'd77;
  localparam logic [LUMA_W-1:0] EDGE_LIMIT = 8'd18;
  localparam logic [LUMA_W-1:0] LUMA_MAX   = 8'd255;
  localparam logic [LUMA_W-1:0] LUMA_MIN   = 8'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CROP_WIDTH     = 2'd0,
    REG_CROP_HEIGHT    = 2'd1,
    REG_MIN_LUMA_RANGE = 2'd2,
    REG_MIN_EDGE_FRAC  = 2'd3
  } cfg_reg_t;

  // One line store entry: luma of the pixel above and its horizontal edge flag
  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              hedge;
  } line_entry_t;

  // Weighted luma, integer part only
  function automatic logic [LUMA_W-1:0] luma_of(input logic [7:0] b,
                                                input logic [7:0] g,
                                                input logic [7:0] r);
    logic [15:0] sum;
    sum = 16'(b) * COEF_BLUE + 16'(g) * COEF_GREEN + 16'(r) * COEF_RED;
    return sum[15:8];
  endfunction

  // Absolute luma difference at or above the edge threshold
  function automatic logic is_edge(input logic [LUMA_W-1:0] a,
                                   input logic [LUMA_W-1:0] b);
    logic [LUMA_W-1:0] diff;
    diff = (a >= b) ? (a - b) : (b - a);
    return diff >= EDGE_LIMIT;
  endfunction

  // Zero counts as one, anything above the limit saturates
  function automatic logic [DIM_CFG_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v,
                                                     input logic [DIM_CFG_W-1:0] lim);
    logic [DIM_CFG_W-1:0] res;
    if (v == '0) begin
      res = DIM_CFG_W'(1);
    end else if (v > lim) begin
      res = lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- design/clas_pixel_if.sv -----
// Pixel input channel: valid/ready handshake with BGR payload.
`timescale 1ns / 1ps
interface clas_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [clas_pkg::LUMA_W-1:0] pixel_blue;
  logic [clas_pkg::LUMA_W-1:0] pixel_green;
  logic [clas_pkg::LUMA_W-1:0] pixel_red;

  modport source (output valid, output pixel_blue, output pixel_green, output pixel_red,
                  input ready);
  modport sink (input valid, input pixel_blue, input pixel_green, input pixel_red,
                output ready);
endinterface

// ----- design/clas_result_if.sv -----
// Result output channel: valid/ready handshake with crop statistics payload.
`timescale 1ns / 1ps
interface clas_result_if;
  logic                          valid;
  logic                          ready;
  logic [clas_pkg::LUMA_W-1:0]    lowest_luma;
  logic [clas_pkg::LUMA_W-1:0]    highest_luma;
  logic [clas_pkg::OUT_CNT_W-1:0] edge_hits;
  logic [clas_pkg::OUT_CNT_W-1:0] tested_pixels;
  logic                          low_information;

  modport source (output valid, output lowest_luma, output highest_luma, output edge_hits,
                  output tested_pixels, output low_information, input ready);
  modport sink (input valid, input lowest_luma, input highest_luma, input edge_hits,
                input tested_pixels, input low_information, output ready);
endinterface

// ----- design/clas_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and data.
`timescale 1ns / 1ps
interface clas_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [clas_pkg::CFG_IDX_W-1:0]  index;
  logic [clas_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/clas_line_store.sv -----
// One-row line store: synchronous memory with registered read and write-to-read bypass.
`timescale 1ns / 1ps
module clas_line_store #(
  parameter int DEPTH = clas_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output clas_pkg::line_entry_t      rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  clas_pkg::line_entry_t      wr_data
);
  import clas_pkg::*;

  line_entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, bypass a write to the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ----- design/crop_luma_appearance_stats.sv -----
// Top level: crop luma min/max, gradient edge count and low-information flag.
//
//  Channel  Role   Transaction carries
//  -------  -----  ----------------------------------------------------------
//  pixel    sink   one BGR pixel of the crop, raster order
//  cfg      sink   register index and write data (width, height, thresholds)
//  result   source min, max, edge hits, tested pixels, low-information flag
//
// One pixel per cycle sustained; an accepted pixel is registered into the line
// store read stage, and the crop result is loaded into the output register when
// the last pixel leaves that stage. The line store has one read and one write
// port, which sets the single-pixel-per-cycle rate. Reset is synchronous and
// needs no clearing pass. Pixels keep flowing while a result waits; only the
// last pixel of the next crop holds when the previous result is still untaken.
`timescale 1ns / 1ps
module crop_luma_appearance_stats #(
  parameter int MAX_WIDTH  = clas_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = clas_pkg::MAX_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  clas_pixel_if.sink      pixel,
  clas_cfg_if.sink        cfg,
  clas_result_if.source   result
);
  import clas_pkg::*;

  // Geometry limits: an 8-bit register cannot exceed 255
  localparam int WLIM   = (MAX_WIDTH  < 255) ? MAX_WIDTH  : 255;
  localparam int HLIM   = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = $clog2(WLIM + 1);
  localparam int HDIM_W = $clog2(HLIM + 1);
  localparam int SMUL_W = WDIM_W + HDIM_W;
  localparam int CNT_W  = $clog2((WLIM - 1) * (HLIM - 1) + 1);
  localparam int PROD_W = CNT_W + THR_W;

  // Configuration registers
  logic [WDIM_W-1:0] width_eff;
  logic [HDIM_W-1:0] height_eff;
  logic [LUMA_W-1:0] luma_range_min;
  logic [THR_W-1:0]  edge_frac_min;

  logic [WDIM_W-1:0] width_next;
  logic [HDIM_W-1:0] height_next;
  logic [SMUL_W-1:0] samples_next;
  logic [CNT_W-1:0]  sample_count;
  logic [PROD_W-1:0] thr_product;
  logic              cfg_write;
  logic              geom_write;

  // Crop position
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic             col_last;
  logic             row_last;

  // Line store read stage
  logic              s_valid;
  logic [LUMA_W-1:0] s_luma;
  logic [COL_W-1:0]  s_col;
  logic              s_first;
  logic              s_vtest;
  logic              s_last;
  line_entry_t       above;
  line_entry_t       wr_entry;
  logic              wr_en;

  // Running statistics
  logic [LUMA_W-1:0] running_min;
  logic [LUMA_W-1:0] running_max;
  logic [CNT_W-1:0]  edge_total;
  logic [LUMA_W-1:0] left_luma;
  logic [LUMA_W-1:0] min_new;
  logic [LUMA_W-1:0] max_new;
  logic [CNT_W-1:0]  hits_new;
  logic              edge_hit;
  logic              low_range;
  logic              low_frac;

  // Output register
  logic              out_valid;
  logic              stall;
  logic              advance;
  logic              accept;

  // Handshake
  assign stall   = s_valid && s_last && out_valid && !result.ready;
  assign advance = s_valid && !stall;
  assign pixel.ready = !rst && !stall;
  assign accept  = pixel.valid && pixel.ready;
  assign cfg.ready = !rst;
  assign cfg_write = cfg.valid && cfg.ready;
  assign geom_write = cfg_write &&
                      ((cfg.index == REG_CROP_WIDTH) || (cfg.index == REG_CROP_HEIGHT));

  // Next geometry, seen at the write so the sample count is ready by the next pixel
  always_comb begin
    width_next  = width_eff;
    height_next = height_eff;
    if (rst) begin
      width_next  = WDIM_W'(clamp_dim(CROP_WIDTH_RST, DIM_CFG_W'(WLIM)));
      height_next = HDIM_W'(clamp_dim(CROP_HEIGHT_RST, DIM_CFG_W'(HLIM)));
    end else if (cfg_write) begin
      case (cfg.index)
        REG_CROP_WIDTH: begin
          width_next = WDIM_W'(clamp_dim(cfg.data[DIM_CFG_W-1:0], DIM_CFG_W'(WLIM)));
        end
        REG_CROP_HEIGHT: begin
          height_next = HDIM_W'(clamp_dim(cfg.data[DIM_CFG_W-1:0], DIM_CFG_W'(HLIM)));
        end
        default: begin
        end
      endcase
    end
  end

  assign samples_next = SMUL_W'(width_next - WDIM_W'(1)) * SMUL_W'(height_next - HDIM_W'(1));

  // Track sample count and the threshold product every cycle
  always_ff @(posedge clk) begin
    sample_count <= samples_next[CNT_W-1:0];
    thr_product  <= PROD_W'(edge_frac_min) * PROD_W'(sample_count);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff      <= width_next;
      height_eff     <= height_next;
      luma_range_min <= LUMA_RANGE_RST;
      edge_frac_min  <= EDGE_FRAC_RST;
    end else begin
      width_eff  <= width_next;
      height_eff <= height_next;
      if (cfg_write) begin
        case (cfg.index)
          REG_MIN_LUMA_RANGE: luma_range_min <= cfg.data[LUMA_W-1:0];
          REG_MIN_EDGE_FRAC:  edge_frac_min  <= cfg.data[THR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Position decode
  assign col_last = (WDIM_W'(col_pos) == (width_eff - WDIM_W'(1)));
  assign row_last = (HDIM_W'(row_pos) == (height_eff - HDIM_W'(1)));

  // Advance the raster position and load the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      s_valid <= 1'b0;
    end else begin
      if (accept) begin
        s_valid <= 1'b1;
      end else if (advance) begin
        s_valid <= 1'b0;
      end
      if (accept) begin
        if (col_last) begin
          col_pos <= '0;
          row_pos <= row_last ? '0 : row_pos + ROW_W'(1);
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
      end
      if (geom_write) begin
        col_pos <= '0;
        row_pos <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_luma  <= luma_of(pixel.pixel_blue, pixel.pixel_green, pixel.pixel_red);
      s_col   <= col_pos;
      s_first <= (col_pos == '0);
      s_vtest <= (row_pos != '0) && !col_last;
      s_last  <= col_last && row_last;
    end
  end

  // Line store: read the entry above on accept, write back the left neighbour
  assign wr_en          = advance && !s_first;
  assign wr_entry.luma  = left_luma;
  assign wr_entry.hedge = is_edge(left_luma, s_luma);

  clas_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (above),
    .wr_en   (wr_en),
    .wr_addr (s_col - COL_W'(1)),
    .wr_data (wr_entry)
  );

  // Update statistics for the pixel in the read stage
  assign edge_hit  = s_vtest && (is_edge(s_luma, above.luma) || above.hedge);
  assign min_new   = (s_luma < running_min) ? s_luma : running_min;
  assign max_new   = (s_luma > running_max) ? s_luma : running_max;
  assign hits_new  = edge_total + CNT_W'(edge_hit);
  assign low_range = (max_new - min_new) < luma_range_min;
  assign low_frac  = (sample_count == '0) ? (edge_frac_min != '0) :
                     (PROD_W'({hits_new, FRAC_SHIFT'(0)}) < thr_product);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= LUMA_MAX;
      running_max <= LUMA_MIN;
      edge_total  <= '0;
      left_luma   <= '0;
    end else begin
      if (advance) begin
        if (s_last) begin
          running_min <= LUMA_MAX;
          running_max <= LUMA_MIN;
          edge_total  <= '0;
          left_luma   <= '0;
        end else begin
          running_min <= min_new;
          running_max <= max_new;
          edge_total  <= hits_new;
          left_luma   <= s_luma;
        end
      end
      if (geom_write) begin
        running_min <= LUMA_MAX;
        running_max <= LUMA_MIN;
        edge_total  <= '0;
        left_luma   <= '0;
      end
    end
  end

  // Output register: load on the last pixel, drop on transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_last) begin
      result.lowest_luma     <= min_new;
      result.highest_luma    <= max_new;
      result.edge_hits       <= OUT_CNT_W'(hits_new);
      result.tested_pixels   <= OUT_CNT_W'(sample_count);
      result.low_information <= low_range || low_frac;
    end
  end

  assign result.valid = out_valid;

  // Checks
  a_edges_bounded: assert property (@(posedge clk) disable iff (rst)
    edge_total <= sample_count)
    else $error("edge total exceeds sample count");

  a_col_in_crop: assert property (@(posedge clk) disable iff (rst)
    WDIM_W'(col_pos) < width_eff)
    else $error("column position outside crop");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && s_last))
    else $error("result raised without a last pixel");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> (s_valid && s_last && $stable(s_luma) && $stable(s_col)))
    else $error("stalled pixel lost its stage");

endmodule
